[sv/mph_pkg.sv]
// Shared types, codes and key compare for the message priority heap.
`timescale 1ns / 1ps
package mph_pkg;

    // Operation codes
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One stored heap entry: priority over time forms the ordering key
    typedef struct packed {
        logic [7:0]  prio;
        logic [23:0] tstamp;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic        func;
        logic [7:0]  msg_priority;
        logic [23:0] msg_time;
        logic [31:0] msg_payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [7:0]  out_priority;
        logic [23:0] out_time;
        logic [31:0] out_payload;
        logic [8:0]  occupancy;
    } t_out_item;

    // True when entry b is strictly more urgent than entry a
    function automatic logic key_gt(input t_entry a, input t_entry b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = {a.prio, a.tstamp};
        kb = {b.prio, b.tstamp};
        return ka > kb;
    endfunction

endpackage

[sv/message_priority_heap_core.sv]
// Top level: min-heap priority queue of messages, sifting through one memory.
// An insert compares the new entry with one parent per step; a remove reads the top and the last
// entry, then reads the left child and, where there is one, the right child at each level.
// A refused item goes straight to its result. Items run one at a time.
// The result register lets the next item enter; a waiting result holds its final step.
// Reset (synchronous, active low) empties the heap; memory contents are not cleared.
`timescale 1ns / 1ps
module message_priority_heap_core #(
    parameter int CAPACITY = 256,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mph_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mph_pkg::t_out_item  o_out_item
);
    import mph_pkg::*;

    localparam int XW = AW + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_RM_TOP  = 3'd2;
    localparam logic [2:0] S_RM_LAST = 3'd3;
    localparam logic [2:0] S_DN_C1   = 3'd4;
    localparam logic [2:0] S_DN_C2   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_hole, n_hole;
    logic [AW-1:0] r_cidx, n_cidx;
    t_entry        r_elem, n_elem;
    t_entry        r_child, n_child;
    t_entry        r_top, n_top;
    logic [1:0]    r_status, n_status;
    logic          r_rvld, n_rvld;
    logic          r_wr_e, n_wr_e;
    logic          r_ovld;
    t_out_item     r_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic          in_acc;
    logic          out_load;
    logic          full;
    logic [AW-1:0] up_idx;
    logic [AW-1:0] up_up_idx;
    logic [XW-1:0] c1_idx;
    logic [XW-1:0] c2_idx;
    logic [XW-1:0] cnt_x;
    logic          has_c2;
    t_entry        dn_best;
    logic [AW-1:0] dn_bidx;
    logic [XW-1:0] nc1_idx;
    t_entry        in_entry;
    t_out_item     res;
    logic [CW+8:0] occ_ext;

    mph_store #(
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(CAPACITY));

    assign in_entry.prio    = i_in_item.msg_priority;
    assign in_entry.tstamp  = i_in_item.msg_time;
    assign in_entry.payload = i_in_item.msg_payload;

    // Index arithmetic for parent and children of the hole
    assign up_idx    = AW'((r_hole - AW'(1)) >> 1);
    assign up_up_idx = AW'((up_idx - AW'(1)) >> 1);
    assign c1_idx    = {1'b0, r_hole, 1'b1};
    assign c2_idx    = c1_idx + XW'(1);
    assign cnt_x     = XW'(r_count);
    assign has_c2    = (c2_idx < cnt_x);

    // Pick the more urgent child; ties keep the left child
    always_comb begin
        if (r_state == S_DN_C2) begin
            if (key_gt(r_child, mem_rdata)) begin
                dn_best = mem_rdata;
                dn_bidx = c2_idx[AW-1:0];
            end else begin
                dn_best = r_child;
                dn_bidx = r_cidx;
            end
        end else begin
            dn_best = mem_rdata;
            dn_bidx = c1_idx[AW-1:0];
        end
    end
    assign nc1_idx = {1'b0, dn_bidx, 1'b1};

    // Sequencer: read, compare, move one level per step
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hole    = r_hole;
        n_cidx    = r_cidx;
        n_elem    = r_elem;
        n_child   = r_child;
        n_top     = r_top;
        n_status  = r_status;
        n_rvld    = r_rvld;
        n_wr_e    = r_wr_e;
        mem_we    = 1'b0;
        mem_waddr = r_hole;
        mem_wdata = r_elem;
        mem_re    = 1'b0;
        mem_raddr = '0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_rvld   = 1'b0;
                    n_wr_e   = 1'b0;
                    if (i_in_item.func == FN_INSERT) begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_elem  = in_entry;
                            n_hole  = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_wr_e  = 1'b1;
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'((r_count[AW-1:0] - AW'(1)) >> 1);
                                n_state   = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_state   = S_RM_TOP;
                        end
                    end
                end
            end
            S_UP: begin
                // Move the parent down while it is less urgent
                if (key_gt(mem_rdata, r_elem)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hole;
                    mem_wdata = mem_rdata;
                    n_hole    = up_idx;
                    if (up_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = up_up_idx;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_TOP: begin
                n_top     = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = AW'(r_count - CW'(1));
                n_state   = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_elem  = mem_rdata;
                n_count = r_count - CW'(1);
                n_hole  = '0;
                n_rvld  = 1'b1;
                if (r_count == CW'(1)) begin
                    n_wr_e  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_wr_e = 1'b1;
                    if (r_count > CW'(2)) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(1);
                        n_state   = S_DN_C1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DN_C1, S_DN_C2: begin
                if (r_state == S_DN_C1 && has_c2) begin
                    // Hold the left child, fetch the right one
                    n_child   = mem_rdata;
                    n_cidx    = c1_idx[AW-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = c2_idx[AW-1:0];
                    n_state   = S_DN_C2;
                end else if (key_gt(r_elem, dn_best)) begin
                    // Lift the child into the hole and descend
                    mem_we    = 1'b1;
                    mem_waddr = r_hole;
                    mem_wdata = dn_best;
                    n_hole    = dn_bidx;
                    if (nc1_idx < cnt_x) begin
                        mem_re    = 1'b1;
                        mem_raddr = nc1_idx[AW-1:0];
                        n_state   = S_DN_C1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Drop the moving entry into its final slot, post the result
                mem_we    = r_wr_e;
                mem_waddr = r_hole;
                mem_wdata = r_elem;
                if (!r_ovld || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Assemble the result item
    assign occ_ext          = {9'd0, r_count};
    assign res.status       = r_status;
    assign res.out_valid    = r_rvld;
    assign res.out_priority = r_rvld ? r_top.prio : 8'd0;
    assign res.out_time     = r_rvld ? r_top.tstamp : 24'd0;
    assign res.out_payload  = r_rvld ? r_top.payload : 32'd0;
    assign res.occupancy    = occ_ext[8:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_hole   <= n_hole;
        r_cidx   <= n_cidx;
        r_elem   <= n_elem;
        r_child  <= n_child;
        r_top    <= n_top;
        r_status <= n_status;
        r_rvld   <= n_rvld;
        r_wr_e   <= n_wr_e;
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule

[sv/mph_store.sv]
// Heap entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module mph_store #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  mph_pkg::t_entry  i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output mph_pkg::t_entry  o_rd_data
);
    import mph_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read entry, data valid next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[tb/sv/tb.sv]
// Testbench for the message priority heap: random and directed traffic checked against a shadow heap.
`timescale 1ns / 1ps
module tb;
    import mph_pkg::*;

    localparam int CAPACITY  = 256;
    localparam int CALM_TAIL = 120;     // last items sent with no idling on either side
    localparam int MIX_CHUNK = 50;

    typedef struct {
        bit       wait_drain;
        t_in_item item;
    } t_stim_op;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;

    t_stim_op   msg_ops[$];
    t_stim_op   next_op;
    t_out_item  awaited_results[$];
    t_out_item  got_expect;
    t_entry     shadow_heap[CAPACITY];
    int unsigned shadow_count = 0;
    int         plan_count = 0;
    int         mismatches = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    logic       in_taken = 1'b0;

    message_priority_heap_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // True when entry a must leave the heap before entry b
    function automatic bit ahead(input t_entry a, input t_entry b);
        return {a.prio, a.tstamp} < {b.prio, b.tstamp};
    endfunction

    // Apply one operation to the shadow heap and return the result it produces
    function automatic t_out_item heap_predict(input t_in_item op);
        t_out_item   r;
        t_entry      top;
        t_entry      tmp;
        int unsigned k;
        int unsigned up;
        int unsigned c;
        r = '0;
        if (op.func == FN_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                k = shadow_count;
                shadow_heap[k] = {op.msg_priority, op.msg_time, op.msg_payload};
                shadow_count++;
                // sift up while the new entry beats its parent
                while (k > 0) begin
                    up = (k - 1) / 2;
                    if (!ahead(shadow_heap[k], shadow_heap[up]))
                        break;
                    tmp = shadow_heap[up];
                    shadow_heap[up] = shadow_heap[k];
                    shadow_heap[k] = tmp;
                    k = up;
                end
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                top = shadow_heap[0];
                shadow_count--;
                shadow_heap[0] = shadow_heap[shadow_count];
                shadow_heap[shadow_count] = top;
                k = 0;
                // sift down toward the more urgent child
                while (2 * k + 1 < shadow_count) begin
                    c = 2 * k + 1;
                    if (c + 1 < shadow_count && ahead(shadow_heap[c + 1], shadow_heap[c]))
                        c++;
                    if (!ahead(shadow_heap[c], shadow_heap[k]))
                        break;
                    tmp = shadow_heap[c];
                    shadow_heap[c] = shadow_heap[k];
                    shadow_heap[k] = tmp;
                    k = c;
                end
                r.out_valid    = 1'b1;
                r.out_priority = top.prio;
                r.out_time     = top.tstamp;
                r.out_payload  = top.payload;
            end
        end
        r.occupancy = shadow_count[8:0];
        return r;
    endfunction

    // Priorities lean on a few values so that ties are common
    function automatic logic [7:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_time();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_payload();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Queue one operation and track the heap size the plan leads to
    task automatic add_op(input logic func, input logic [7:0] p, input logic [23:0] t,
                          input logic [31:0] pay, input bit drain);
        t_stim_op s;
        s.wait_drain = drain;
        s.item = '{func: func, msg_priority: p, msg_time: t, msg_payload: pay};
        msg_ops.push_back(s);
        if (func == FN_INSERT && plan_count < CAPACITY)
            plan_count++;
        else if (func == FN_REMOVE && plan_count > 0)
            plan_count--;
    endtask

    task automatic add_random(input logic func, input bit drain);
        add_op(func, rand_prio(), rand_time(), rand_payload(), drain);
    endtask

    // Accept items and record what each must produce
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            awaited_results.push_back(heap_predict(in_item));
    end

    // Drive items, with idle bursts and drain pauses
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (msg_ops.size() == 0) begin
                in_valid <= 1'b0;
            end else if (msg_ops[0].wait_drain && awaited_results.size() != 0) begin
                in_valid <= 1'b0;
            end else if (msg_ops.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(1, 13) - 1;
                in_valid <= 1'b0;
            end else begin
                next_op = msg_ops.pop_front();
                in_item <= next_op.item;
                in_valid <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with none expected: status 0x%0h occupancy %0d",
                       out_item.status, out_item.occupancy);
                mismatches++;
            end else begin
                got_expect = awaited_results.pop_front();
                check_field("status", got_expect.status, out_item.status);
                check_field("out_valid", got_expect.out_valid, out_item.out_valid);
                check_field("out_priority", got_expect.out_priority, out_item.out_priority);
                check_field("out_time", got_expect.out_time, out_item.out_time);
                check_field("out_payload", got_expect.out_payload, out_item.out_payload);
                check_field("occupancy", got_expect.occupancy, out_item.occupancy);
            end
        end
    end

    // Stall the result side in bursts
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else if (msg_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int i;
        int ins_pct;

        // Directed: empty remove, field extremes, priority ties and exact ties
        add_op(FN_REMOVE, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        add_op(FN_INSERT, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        add_op(FN_INSERT, 8'h00, 24'h000000, 32'h0000_0000, 1'b0);
        add_op(FN_INSERT, 8'h07, 24'd100, 32'hA5A5_0001, 1'b0);
        add_op(FN_INSERT, 8'h07, 24'd50, 32'hA5A5_0002, 1'b0);
        add_op(FN_INSERT, 8'h07, 24'd50, 32'hA5A5_0003, 1'b0);
        add_op(FN_INSERT, 8'h07, 24'd50, 32'hA5A5_0004, 1'b0);
        add_op(FN_INSERT, 8'h00, 24'hFFFFFF, 32'h5A5A_5A5A, 1'b0);
        add_op(FN_INSERT, 8'h80, 24'h800000, 32'h8000_0000, 1'b0);
        for (i = 0; i < 9; i++)
            add_op(FN_REMOVE, 8'h00, 24'h000000, 32'h0000_0000, 1'b0);
        add_op(FN_REMOVE, 8'h55, 24'hAAAAAA, 32'h5555_5555, 1'b0);

        // Mixed traffic, insert share varying by chunk
        for (i = 0; i < 8 * MIX_CHUNK; i++) begin
            if (i % MIX_CHUNK == 0)
                ins_pct = $urandom_range(30, 80);
            add_random(($urandom_range(0, 99) < ins_pct) ? FN_INSERT : FN_REMOVE,
                       $urandom_range(0, 99) == 0);
        end

        // Fill to capacity, then push against the full heap
        add_random(FN_INSERT, 1'b1);
        while (plan_count < CAPACITY)
            add_random(FN_INSERT, 1'b0);
        for (i = 0; i < 3; i++)
            add_random(FN_INSERT, 1'b0);
        add_random(FN_REMOVE, 1'b0);
        add_random(FN_INSERT, 1'b0);
        add_random(FN_INSERT, 1'b0);

        // Drain to empty, then remove from the empty heap
        while (plan_count > 0)
            add_random(FN_REMOVE, 1'b0);
        add_random(FN_REMOVE, 1'b0);
        add_random(FN_REMOVE, 1'b0);

        // Closing mixed traffic; its tail runs with no idling
        add_random(FN_INSERT, 1'b1);
        for (i = 0; i < 160; i++)
            add_random(($urandom_range(0, 99) < 55) ? FN_INSERT : FN_REMOVE, 1'b0);

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all items to go in and all results to come back
        while (msg_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Overall time limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/mph_pkg.sv
sv/mph_store.sv
sv/message_priority_heap_core.sv
tb/sv/tb.sv
